// ===== design/rttm_pkg.sv =====
// Shared types, codes and widths of the radar track table manager.
package rttm_pkg;

    localparam int MAX_TRACKS_DEF = 32;
    localparam int LIST_CAP       = 32;

    localparam int COORD_W   = 16;
    localparam int ID_W      = 16;
    localparam int CNT_W     = 8;
    localparam int SLOT_W    = 5;
    localparam int CFG_W     = 8;

    localparam int S_TDATA_W = 72;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 88;
    localparam int M_TUSER_W = 3;

    localparam int PADDR_W   = 3;
    localparam int PDATA_W   = 32;

    localparam logic REG_INIT_FRAMES = 1'b0;
    localparam logic REG_LOSE_FRAMES = 1'b1;

    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    typedef enum logic [1:0] {
        OP_ASSOC = 2'd0,
        OP_MISS  = 2'd1,
        OP_BIRTH = 2'd2,
        OP_END   = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_FULL      = 2'd1,
        STATUS_BAD_INDEX = 2'd2,
        STATUS_LIST      = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        TRK_INIT     = 2'd0,
        TRK_ACTIVE   = 2'd1,
        TRK_OCCLUDED = 2'd2,
        TRK_DELETED  = 2'd3
    } trk_state_t;

    typedef struct packed {
        logic [CNT_W-1:0]   misses;
        logic [CNT_W-1:0]   hits;
        logic [COORD_W-1:0] vel;
        logic [COORD_W-1:0] z;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
        trk_state_t         state;
        logic [ID_W-1:0]    id;
    } track_entry_t;

    typedef struct packed {
        logic [CFG_W-1:0] init_frames;
        logic [CFG_W-1:0] lose_frames;
    } track_cfg_t;

endpackage

// ===== design/rttm_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module rttm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/rttm_upd.sv =====
// Hit and miss update of one stored track for associate and miss operations.
module rttm_upd (
    input  rttm_pkg::track_entry_t       cur,
    input  logic                         is_miss,
    input  logic [rttm_pkg::COORD_W-1:0] meas_x,
    input  logic [rttm_pkg::COORD_W-1:0] meas_y,
    input  logic [rttm_pkg::COORD_W-1:0] meas_z,
    input  logic [rttm_pkg::COORD_W-1:0] meas_vel,
    input  rttm_pkg::track_cfg_t         cfg,
    output rttm_pkg::track_entry_t       nxt
);
    import rttm_pkg::*;

    logic [CNT_W-1:0] hits_inc;
    logic [CNT_W-1:0] misses_inc;

    assign hits_inc   = (cur.hits == CNT_MAX) ? cur.hits : cur.hits + CNT_W'(1);
    assign misses_inc = (cur.misses == CNT_MAX) ? cur.misses : cur.misses + CNT_W'(1);

    always_comb
    begin
        nxt = cur;
        if (is_miss)
        begin
            nxt.misses = misses_inc;
            nxt.hits   = '0;
            nxt.state  = (misses_inc >= cfg.lose_frames) ? TRK_DELETED : TRK_OCCLUDED;
        end
        else
        begin
            nxt.x      = meas_x;
            nxt.y      = meas_y;
            nxt.z      = meas_z;
            nxt.vel    = meas_vel;
            nxt.hits   = hits_inc;
            nxt.misses = '0;
            if (hits_inc >= cfg.init_frames)
            begin
                nxt.state = TRK_ACTIVE;
            end
        end
    end

endmodule

// ===== design/radar_track_table_manager_unit.sv =====
// Top level of the radar track table manager: control sequencer, registers, output stage.
//
// Commands enter on the s_axis channel (opcode in tuser) and results leave on
// m_axis, one transfer per result, tlast on the final result of a command.
// init_frames and lose_frames are written through the APB port at 0x0 and 0x4 by
// the user only while idle, which the block does not enforce; pready is always high.
// Associate, miss and birth read the track RAM when the command is taken, then
// update and write it back as the result is loaded into the output register.
// End of frame walks the stored tracks, a read state and a check-and-write
// state per track, to compact them, then reads back the survivors, a read and
// an output state per listed result, through the single read port of the RAM.
// The output register holds a result while m_axis_tready is low; a new command
// is taken once the previous one has placed its last result in that register.
// Reset empties the table (track count 0), sets the next id to 1 and the
// thresholds to 3 and 5. The RAM needs no clearing pass: only slots below
// the track count are read, and each is written by a birth first.
module radar_track_table_manager_unit #(
    parameter int MAX_TRACKS = rttm_pkg::MAX_TRACKS_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    // tdata: track_index[4:0], pos_x[20:5], pos_y[36:21], pos_z[52:37], velocity[68:53]
    input  logic [rttm_pkg::S_TDATA_W-1:0] s_axis_tdata,
    // tuser: opcode[1:0]
    input  logic [rttm_pkg::S_TUSER_W-1:0] s_axis_tuser,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    // tdata: slot[4:0], track_id[20:5], track_state[22:21], out_x[38:23],
    //        out_y[54:39], out_z[70:55], out_velocity[86:71]
    output logic [rttm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    // tuser: status[1:0], entry_valid[2]
    output logic [rttm_pkg::M_TUSER_W-1:0] m_axis_tuser,
    output logic                           m_axis_tlast,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [rttm_pkg::PADDR_W-1:0]   paddr,
    input  logic [rttm_pkg::PDATA_W-1:0]   pwdata,
    output logic [rttm_pkg::PDATA_W-1:0]   prdata,
    output logic                           pready
);
    import rttm_pkg::*;

    localparam int AW  = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
    localparam int CW  = $clog2(MAX_TRACKS + 1);
    localparam int XW  = (CW > SLOT_W) ? CW : SLOT_W;
    localparam int LW  = $clog2(LIST_CAP + 1);
    localparam int NW  = (CW > LW) ? CW : LW;
    localparam int EW  = $bits(track_entry_t);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_EXEC = 6'b000010,
        S_CRD  = 6'b000100,
        S_CCHK = 6'b001000,
        S_LRD  = 6'b010000,
        S_LOUT = 6'b100000
    } fsm_t;

    fsm_t               state_reg, state_next;
    op_t                op_reg, op_next;
    logic [SLOT_W-1:0]  idx_reg, idx_next;
    logic [COORD_W-1:0] mx_reg, my_reg, mz_reg, mv_reg;
    logic [CW-1:0]      count_reg, count_next;
    logic [ID_W-1:0]    next_id_reg, next_id_next;
    logic [CW-1:0]      i_reg, i_next;
    logic [CW-1:0]      kept_reg, kept_next;
    logic [NW-1:0]      j_reg, j_next;
    track_cfg_t         cfg_reg;

    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TUSER_W-1:0] m_tuser_reg;
    logic                 m_tlast_reg;

    logic             accept;
    logic             out_free;
    logic             out_load;
    status_t          o_status;
    logic [SLOT_W-1:0] o_slot;
    track_entry_t     o_entry;
    logic             o_valid;
    logic             o_last;

    logic             ram_we, ram_re;
    logic [AW-1:0]    ram_waddr, ram_raddr;
    track_entry_t     ram_wdata, ram_rentry, upd_entry, birth_entry;
    logic [EW-1:0]    ram_rdata;

    logic             survivor;
    logic [CW-1:0]    kept_inc, i_inc;
    logic [NW-1:0]    list_n, j_inc;
    logic             cfg_write;

    rttm_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_TRACKS)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign ram_rentry = track_entry_t'(ram_rdata);

    rttm_upd u_upd (
        .cur      (ram_rentry),
        .is_miss  (op_reg == OP_MISS),
        .meas_x   (mx_reg),
        .meas_y   (my_reg),
        .meas_z   (mz_reg),
        .meas_vel (mv_reg),
        .cfg      (cfg_reg),
        .nxt      (upd_entry)
    );

    always_comb
    begin
        birth_entry        = '0;
        birth_entry.id     = next_id_reg;
        birth_entry.state  = TRK_INIT;
        birth_entry.x      = mx_reg;
        birth_entry.y      = my_reg;
        birth_entry.z      = mz_reg;
        birth_entry.vel    = mv_reg;
        birth_entry.hits   = CNT_W'(1);
        birth_entry.misses = '0;
    end

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign out_free      = !m_tvalid_reg || m_axis_tready;

    assign survivor = (ram_rentry.state != TRK_DELETED);
    assign kept_inc = kept_reg + CW'(survivor);
    assign i_inc    = i_reg + CW'(1);
    assign j_inc    = j_reg + NW'(1);
    assign list_n   = (NW'(count_reg) > NW'(LIST_CAP)) ? NW'(LIST_CAP) : NW'(count_reg);

    always_comb
    begin
        state_next   = state_reg;
        op_next      = op_reg;
        idx_next     = idx_reg;
        count_next   = count_reg;
        next_id_next = next_id_reg;
        i_next       = i_reg;
        kept_next    = kept_reg;
        j_next       = j_reg;
        ram_we       = 1'b0;
        ram_waddr    = '0;
        ram_wdata    = upd_entry;
        ram_re       = 1'b0;
        ram_raddr    = '0;
        out_load     = 1'b0;
        o_status     = STATUS_OK;
        o_slot       = '0;
        o_entry      = '0;
        o_valid      = 1'b0;
        o_last       = 1'b1;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next    = op_t'(s_axis_tuser);
                    idx_next   = s_axis_tdata[SLOT_W-1:0];
                    ram_re     = 1'b1;
                    ram_raddr  = AW'(s_axis_tdata[SLOT_W-1:0]);
                    state_next = S_EXEC;
                    if (op_t'(s_axis_tuser) == OP_END)
                    begin
                        i_next    = '0;
                        kept_next = '0;
                        if (count_reg != '0)
                        begin
                            state_next = S_CRD;
                        end
                    end
                end
            end

            S_EXEC:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                    case (op_reg)
                        OP_ASSOC, OP_MISS:
                        begin
                            o_slot = idx_reg;
                            if (XW'(idx_reg) >= XW'(count_reg))
                            begin
                                o_status = STATUS_BAD_INDEX;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                ram_waddr = AW'(idx_reg);
                                ram_wdata = upd_entry;
                                o_entry   = upd_entry;
                                o_valid   = 1'b1;
                            end
                        end
                        OP_BIRTH:
                        begin
                            if (count_reg >= CW'(MAX_TRACKS))
                            begin
                                o_status = STATUS_FULL;
                            end
                            else
                            begin
                                ram_we       = 1'b1;
                                ram_waddr    = AW'(count_reg);
                                ram_wdata    = birth_entry;
                                count_next   = count_reg + CW'(1);
                                next_id_next = next_id_reg + ID_W'(1);
                                o_slot       = SLOT_W'(count_reg);
                                o_entry      = birth_entry;
                                o_valid      = 1'b1;
                            end
                        end
                        default:
                        begin
                            o_status = STATUS_LIST;
                        end
                    endcase
                end
            end

            S_CRD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(i_reg);
                state_next = S_CCHK;
            end

            S_CCHK:
            begin
                i_next    = i_inc;
                kept_next = kept_inc;
                if (survivor)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(kept_reg);
                    ram_wdata = ram_rentry;
                end
                if (i_inc == count_reg)
                begin
                    count_next = kept_inc;
                    j_next     = '0;
                    state_next = (kept_inc == '0) ? S_EXEC : S_LRD;
                end
                else
                begin
                    state_next = S_CRD;
                end
            end

            S_LRD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = AW'(j_reg);
                state_next = S_LOUT;
            end

            S_LOUT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    o_status   = STATUS_LIST;
                    o_slot     = SLOT_W'(j_reg);
                    o_entry    = ram_rentry;
                    o_valid    = 1'b1;
                    o_last     = (j_inc == list_n);
                    j_next     = j_inc;
                    state_next = (j_inc == list_n) ? S_IDLE : S_LRD;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        m_tvalid_next = m_tvalid_reg;
        if (out_load)
        begin
            m_tvalid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            m_tvalid_next = 1'b0;
        end
    end

    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg           <= S_IDLE;
            count_reg           <= '0;
            next_id_reg         <= ID_W'(1);
            m_tvalid_reg        <= 1'b0;
            cfg_reg.init_frames <= CFG_W'(3);
            cfg_reg.lose_frames <= CFG_W'(5);
            i_reg               <= '0;
            kept_reg            <= '0;
            j_reg               <= '0;
            op_reg              <= OP_ASSOC;
        end
        else
        begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            next_id_reg  <= next_id_next;
            m_tvalid_reg <= m_tvalid_next;
            i_reg        <= i_next;
            kept_reg     <= kept_next;
            j_reg        <= j_next;
            op_reg       <= op_next;
            if (cfg_write)
            begin
                case (paddr[2])
                    REG_INIT_FRAMES: cfg_reg.init_frames <= pwdata[CFG_W-1:0];
                    REG_LOSE_FRAMES: cfg_reg.lose_frames <= pwdata[CFG_W-1:0];
                    default:         cfg_reg             <= cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg <= idx_next;
        if (accept)
        begin
            mx_reg <= s_axis_tdata[20:5];
            my_reg <= s_axis_tdata[36:21];
            mz_reg <= s_axis_tdata[52:37];
            mv_reg <= s_axis_tdata[68:53];
        end
        if (out_load)
        begin
            m_tdata_reg <= {1'b0, o_entry.vel, o_entry.z, o_entry.y, o_entry.x,
                            o_entry.state, o_entry.id, o_slot};
            m_tuser_reg <= {o_valid, o_status};
            m_tlast_reg <= o_last;
        end
    end

    assign m_axis_tvalid = m_tvalid_reg;
    assign m_axis_tdata  = m_tdata_reg;
    assign m_axis_tuser  = m_tuser_reg;
    assign m_axis_tlast  = m_tlast_reg;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LOSE_FRAMES) ? PDATA_W'(cfg_reg.lose_frames)
                                                  : PDATA_W'(cfg_reg.init_frames);

endmodule

// ===== design/rttm_checker.sv =====
// Port-level checks of the radar track table manager and their bind.
module rttm_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic [rttm_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [rttm_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input logic                           m_axis_tlast,
    input logic                           m_axis_tvalid,
    input logic                           m_axis_tready
);
    import rttm_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    a_single_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] != STATUS_LIST) |-> m_axis_tlast)
        else $error("non-listing result without tlast");

    a_empty_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[2] |-> (m_axis_tdata[86:5] == '0))
        else $error("track fields set on a result without a track");

    a_full_result: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[1:0] == STATUS_FULL)
        |-> !m_axis_tuser[2] && (m_axis_tdata[4:0] == '0))
        else $error("table full result carries a track");

endmodule

bind radar_track_table_manager_unit rttm_checker u_rttm_checker (.*);
